// File: src/orfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package orfc_pkg;

    // largest frame length accepted in the length field
    localparam int MAX_FRAME_LEN = 256;
    localparam int MIN_FRAME_LEN = 8;

    // byte position counter: holds any position inside a legal frame
    localparam int POS_W = $clog2(MAX_FRAME_LEN + 1);
    // compare width for position against length + 2 and 8 + key count
    localparam int CMP_W = ((POS_W > 9) ? POS_W : 9) + 1;

    // depth of the queue between front and back, a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  SOM_BYTE = 8'h53;
    localparam logic [15:0] CRC_INIT = 16'h1D0F;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // reply codes
    localparam logic [7:0] RC_ACK = 8'h40;
    localparam logic [7:0] RC_NAK = 8'h41;
    localparam logic [7:0] RC_RAW = 8'h50;
    localparam logic [7:0] RC_KPD = 8'h53;
    localparam logic [7:0] RC_COM = 8'h54;

    // item kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // frame status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_BAD_LEN   = 3'd2;
    localparam logic [2:0] ST_CRC_ERR   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;

    typedef enum logic [0:0] {
        PH_IDLE,
        PH_RECV
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload;
        logic [7:0] code;
        logic [2:0] status;
    } item_t;

    // crc of one byte placed in the high half, msb first
    function automatic logic [15:0] crc_tab(input logic [7:0] idx);
        logic [15:0] c;
        c = {idx, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
        return {crc[7:0], 8'h00} ^ crc_tab(crc[15:8] ^ b);
    endfunction

endpackage

`default_nettype wire

// File: src/orfc_rx_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface orfc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

`default_nettype wire

// File: src/orfc_item_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface orfc_item_if;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [7:0] reply_code;
    logic [2:0] frame_status;
    logic       frame_end;

    modport source (output valid, output item_kind, output payload_byte,
                    output reply_code, output frame_status, output frame_end,
                    input ready);
    modport sink   (input valid, input item_kind, input payload_byte,
                    input reply_code, input frame_status, input frame_end,
                    output ready);
endinterface

`default_nettype wire

// File: src/orfc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module orfc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          frame_start,
    input  wire logic          space,
    output logic               in_ready,
    output logic               push,
    output orfc_pkg::item_t    push_item
);
    import orfc_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  len_reg, len_next;
    logic [7:0]        len_lo_reg, len_lo_next;
    logic [15:0]       crc_reg, crc_next_v;
    logic [7:0]        code_reg, code_next;
    logic [7:0]        kc_reg, kc_next;
    logic [7:0]        crc_lo_reg, crc_lo_next;

    logic              acc;
    logic              emit;
    item_t             item;
    logic [15:0]       full_len;
    logic [CMP_W-1:0]  pos_x, len_x, kc_end;
    logic [15:0]       crc_upd;
    logic [15:0]       got_crc;

    assign in_ready = space;
    assign acc      = in_valid && space;
    assign full_len = {rx_byte, len_lo_reg};
    assign pos_x    = CMP_W'(pos_reg);
    assign len_x    = CMP_W'(len_reg);
    assign kc_end   = CMP_W'(kc_reg) + CMP_W'(8);
    assign crc_upd  = crc_next(crc_reg, rx_byte);
    assign got_crc  = {rx_byte, crc_lo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            len_reg    <= '0;
            len_lo_reg <= '0;
            crc_reg    <= CRC_INIT;
            code_reg   <= '0;
            kc_reg     <= '0;
            crc_lo_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            len_lo_reg <= len_lo_next;
            crc_reg    <= crc_next_v;
            code_reg   <= code_next;
            kc_reg     <= kc_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        len_lo_next = len_lo_reg;
        crc_next_v  = crc_reg;
        code_next   = code_reg;
        kc_next     = kc_reg;
        crc_lo_next = crc_lo_reg;
        emit        = 1'b0;
        item        = '0;
        item.code   = code_reg;

        if (acc && frame_start)
        begin
            // new reception drops whatever frame was in progress
            len_next    = '0;
            len_lo_next = '0;
            code_next   = '0;
            kc_next     = '0;
            crc_lo_next = '0;
            item.code   = '0;
            if (rx_byte != SOM_BYTE)
            begin
                phase_next  = PH_IDLE;
                pos_next    = '0;
                crc_next_v  = CRC_INIT;
                emit        = 1'b1;
                item.kind   = KIND_STATUS;
                item.status = ST_BAD_START;
            end
            else
            begin
                phase_next = PH_RECV;
                pos_next   = POS_W'(1);
                crc_next_v = crc_next(CRC_INIT, rx_byte);
            end
        end
        else if (acc)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    // stray byte outside a frame
                end
                PH_RECV:
                begin
                    if (pos_x < CMP_W'(4) || (pos_x + CMP_W'(2)) < len_x)
                    begin
                        crc_next_v = crc_upd;
                        pos_next   = pos_reg + POS_W'(1);
                        case (pos_x)
                            CMP_W'(2): len_lo_next = rx_byte;
                            CMP_W'(5): code_next   = rx_byte;
                            CMP_W'(7): kc_next     = rx_byte;
                            default:   ;
                        endcase
                        if (pos_x == CMP_W'(3))
                        begin
                            if (full_len < 16'(MIN_FRAME_LEN) || full_len > 16'(MAX_FRAME_LEN))
                            begin
                                phase_next  = PH_IDLE;
                                emit        = 1'b1;
                                item.kind   = KIND_STATUS;
                                item.status = ST_BAD_LEN;
                            end
                            else
                            begin
                                len_next = full_len[POS_W-1:0];
                            end
                        end
                        else if (pos_x >= CMP_W'(6))
                        begin
                            if (code_reg == RC_RAW || code_reg == RC_COM)
                            begin
                                emit         = 1'b1;
                                item.kind    = KIND_PAYLOAD;
                                item.payload = rx_byte;
                            end
                            else if (code_reg == RC_KPD && pos_x >= CMP_W'(8) && pos_x < kc_end)
                            begin
                                emit         = 1'b1;
                                item.kind    = KIND_PAYLOAD;
                                item.payload = rx_byte;
                            end
                        end
                    end
                    else if ((pos_x + CMP_W'(2)) == len_x)
                    begin
                        crc_lo_next = rx_byte;
                        pos_next    = pos_reg + POS_W'(1);
                    end
                    else
                    begin
                        // last byte: close the frame
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        item.kind  = KIND_STATUS;
                        if (got_crc != crc_reg)
                            item.status = ST_CRC_ERR;
                        else if (code_reg == RC_ACK || code_reg == RC_NAK ||
                                 code_reg == RC_RAW || code_reg == RC_KPD ||
                                 code_reg == RC_COM)
                            item.status = ST_OK;
                        else
                            item.status = ST_UNKNOWN;
                    end
                end
                default: ;
            endcase
        end
    end

    assign push      = emit;
    assign push_item = item;

    a_payload_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_item.kind == KIND_PAYLOAD) |-> (phase_reg == PH_RECV && !frame_start))
        else $error("payload item outside a frame");

    a_som_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && frame_start && rx_byte == SOM_BYTE) |=> (phase_reg == PH_RECV && pos_reg == POS_W'(1)))
        else $error("start byte did not open a frame");

    a_recv_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RECV) |-> (pos_reg != '0))
        else $error("receiving at position zero");

endmodule

`default_nettype wire

// File: src/orfc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module orfc_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire orfc_pkg::item_t push_item,
    output logic               space,
    output logic               head_valid,
    output orfc_pkg::item_t    head_item,
    input  wire logic          pop
);
    import orfc_pkg::*;

    item_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign space      = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && space;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_drop: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("item pushed into a full queue");

endmodule

`default_nettype wire

// File: src/orfc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module orfc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire orfc_pkg::item_t head_item,
    output logic               pop,
    input  wire logic          out_ready,
    output logic               out_valid,
    output logic               item_kind,
    output logic [7:0]         payload_byte,
    output logic [7:0]         reply_code,
    output logic [2:0]         frame_status,
    output logic               frame_end
);
    import orfc_pkg::*;

    logic   valid_reg, valid_next;
    item_t  item_reg;
    logic   load;

    // output register refills when an item waits and the register is empty or being drained
    assign load       = head_valid && (!valid_reg || out_ready);
    assign pop        = load;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= head_item;
    end

    assign out_valid    = valid_reg;
    assign item_kind    = item_reg.kind;
    assign payload_byte = item_reg.payload;
    assign reply_code   = item_reg.code;
    assign frame_status = item_reg.status;
    assign frame_end    = (item_reg.kind == KIND_STATUS);

endmodule

`default_nettype wire

// File: src/osdp_reply_frame_checker_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | handshake     | payload
// ---------+-----+---------------+-------------------------------------------------
// rx       | in  | valid / ready | rx_byte[7:0], frame_start
// result   | out | valid / ready | item_kind, payload_byte[7:0], reply_code[7:0],
//          |     |               | frame_status[2:0], frame_end
//
// one byte accepted per cycle while rx.ready is high; crc and parsing finish in that cycle
// a result passes the item queue, then the output register, and waits while result stalls
// rx.ready falls only when the two-entry item queue is full, so result stalls back up there
// reset is asynchronous and active low; it leaves the parser idle with the crc at its seed
// no clearing pass: all frame state is in flip-flops cleared by reset

module osdp_reply_frame_checker_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    orfc_rx_if.sink    rx,
    orfc_item_if.source result
);
    import orfc_pkg::*;

    // front to queue
    logic   push;
    item_t  push_item;
    logic   space;

    // queue to back
    logic   head_valid;
    item_t  head_item;
    logic   pop;

    // front: handshake, byte parsing, crc, payload selection, status decision
    orfc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (rx.valid),
        .rx_byte     (rx.rx_byte),
        .frame_start (rx.frame_start),
        .space       (space),
        .in_ready    (rx.ready),
        .push        (push),
        .push_item   (push_item)
    );

    // short queue decoupling the parser from the output side
    orfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .space      (space),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    // back: registered result port
    orfc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .item_kind    (result.item_kind),
        .payload_byte (result.payload_byte),
        .reply_code   (result.reply_code),
        .frame_status (result.frame_status),
        .frame_end    (result.frame_end)
    );

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

// reply frame checker bench: directed frames from a table, then random reply traffic
// every accepted byte runs through a local frame tracker that predicts the result items

module tb;
    import orfc_pkg::*;

    // one expected or observed result item
    typedef struct packed {
        logic       kind;
        logic [7:0] payload;
        logic [7:0] code;
        logic [2:0] status;
        logic       fend;
    } reply_item_t;

    // how a directed row gets its byte: as typed, or from the tracked crc
    typedef enum logic [1:0] {
        FILL_NONE,
        FILL_CRC_LO,
        FILL_CRC_HI,
        FILL_CRC_BAD
    } fill_t;

    typedef struct packed {
        logic [7:0]  b;
        logic        s;
        fill_t       fill;
        logic        typed;
        logic        exp_got;
        reply_item_t exp;
    } dir_row_t;

    localparam reply_item_t NO_ITEM    = '{KIND_PAYLOAD, 8'h00, 8'h00, ST_OK, 1'b0};
    localparam reply_item_t BAD_SOM    = '{KIND_STATUS, 8'h00, 8'h00, ST_BAD_START, 1'b1};
    localparam reply_item_t BAD_LENGTH = '{KIND_STATUS, 8'h00, 8'h00, ST_BAD_LEN, 1'b1};
    localparam reply_item_t ACK_CRC    = '{KIND_STATUS, 8'h00, RC_ACK, ST_CRC_ERR, 1'b1};

    localparam int DIR_ROWS   = 25;
    localparam int RAND_BYTES = 2000;

    // directed stimulus; typed rows carry their own expectation, the rest use the tracker
    localparam dir_row_t PLAN [0:DIR_ROWS-1] = '{
        // stray byte right after reset: ignored
        '{8'h5A, 1'b0, FILL_NONE, 1'b1, 1'b0, NO_ITEM},
        // wrong start byte
        '{8'hFF, 1'b1, FILL_NONE, 1'b1, 1'b1, BAD_SOM},
        // length 7 is too short
        '{SOM_BYTE, 1'b1, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        '{8'hFF, 1'b0, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        '{8'h07, 1'b0, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, FILL_NONE, 1'b1, 1'b1, BAD_LENGTH},
        // frame cut short by a new start
        '{SOM_BYTE, 1'b1, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        '{8'h01, 1'b0, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        // raw reply, length 9, one payload byte, good crc
        '{SOM_BYTE, 1'b1, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        '{8'h09, 1'b0, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        '{8'h80, 1'b0, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        '{RC_RAW, 1'b0, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        '{8'hAA, 1'b0, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, FILL_CRC_LO, 1'b0, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, FILL_CRC_HI, 1'b0, 1'b0, NO_ITEM},
        // ack reply, minimum length, crc high byte flipped
        '{SOM_BYTE, 1'b1, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        '{8'h7F, 1'b0, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        '{8'h08, 1'b0, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        '{RC_ACK, 1'b0, FILL_NONE, 1'b0, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, FILL_CRC_LO, 1'b0, 1'b0, NO_ITEM},
        '{8'h00, 1'b0, FILL_CRC_BAD, 1'b1, 1'b1, ACK_CRC}
    };

    logic clk;
    logic rst_n;

    orfc_rx_if   rx_ch ();
    orfc_item_if res_ch ();

    osdp_reply_frame_checker_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch)
    );

    // tracked frame state
    phase_t      trk_phase;
    logic [15:0] trk_pos;
    logic [15:0] trk_len;
    logic [15:0] trk_crc;
    logic [7:0]  trk_code;
    logic [7:0]  trk_keys;
    logic [7:0]  trk_crc_lo;

    reply_item_t pending_items[$];
    int          err_count;
    int          byte_count;   // accepted bytes the block did not just ignore
    bit          calm;         // while set, no new gap or stall starts on either side

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // crc-16, poly 0x1021, msb first, one byte
    function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic bit known_code(input logic [7:0] c);
        return c == RC_ACK || c == RC_NAK || c == RC_RAW || c == RC_KPD || c == RC_COM;
    endfunction

    // follows the reply parser for one accepted byte; got is set when an item comes out
    task automatic frame_track(input logic [7:0] b, input logic s,
                               output bit got, output reply_item_t it);
        int p;
        int len;
        got = 1'b0;
        it  = NO_ITEM;
        if (s)
        begin
            // new reception: everything starts over
            trk_pos    = '0;
            trk_len    = '0;
            trk_crc    = CRC_INIT;
            trk_code   = '0;
            trk_keys   = '0;
            trk_crc_lo = '0;
            if (b != SOM_BYTE)
            begin
                trk_phase = PH_IDLE;
                got = 1'b1;
                it  = '{KIND_STATUS, 8'h00, trk_code, ST_BAD_START, 1'b1};
            end
            else
            begin
                trk_phase = PH_RECV;
                trk_crc   = crc16_update(trk_crc, b);
                trk_pos   = 16'd1;
            end
        end
        else if (trk_phase == PH_RECV)
        begin
            p   = trk_pos;
            len = trk_len;
            if (p < 4 || p + 2 < len)
            begin
                // header or body byte: goes into the crc
                trk_crc = crc16_update(trk_crc, b);
                if (p == 2)
                    trk_len = {8'h00, b};
                else if (p == 3)
                begin
                    trk_len = {b, trk_len[7:0]};
                    if (trk_len < MIN_FRAME_LEN || trk_len > MAX_FRAME_LEN)
                    begin
                        trk_phase = PH_IDLE;
                        got = 1'b1;
                        it  = '{KIND_STATUS, 8'h00, trk_code, ST_BAD_LEN, 1'b1};
                    end
                end
                else if (p == 5)
                    trk_code = b;
                else if (p == 7)
                    trk_keys = b;
                trk_pos = 16'(p + 1);
                if (!got && p >= 6)
                begin
                    // raw and com pass the whole body, keypad only its key bytes
                    if (trk_code == RC_RAW || trk_code == RC_COM ||
                        (trk_code == RC_KPD && p >= 8 && p < 8 + int'(trk_keys)))
                    begin
                        got = 1'b1;
                        it  = '{KIND_PAYLOAD, b, trk_code, ST_OK, 1'b0};
                    end
                end
            end
            else if (p + 2 == len)
            begin
                trk_crc_lo = b;
                trk_pos    = 16'(p + 1);
            end
            else
            begin
                // last byte: crc check first, then the reply code
                trk_phase = PH_IDLE;
                got = 1'b1;
                it  = '{KIND_STATUS, 8'h00, trk_code, ST_OK, 1'b1};
                if ({b, trk_crc_lo} != trk_crc)
                    it.status = ST_CRC_ERR;
                else if (!known_code(trk_code))
                    it.status = ST_UNKNOWN;
            end
        end
    endtask

    // offers one byte from a falling edge, waits for the handshake, tracks it
    task automatic push_byte(input logic [7:0] b, input logic s,
                             output bit got, output reply_item_t it);
        int gap;
        gap = calm ? 0 : gap_len();
        if (gap > 0)
        begin
            rx_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid       = 1'b1;
        rx_ch.rx_byte     = b;
        rx_ch.frame_start = s;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        if (s || trk_phase == PH_RECV)
            byte_count++;
        frame_track(b, s, got, it);
        @(negedge clk);
    endtask

    task automatic send_tracked(input logic [7:0] b, input logic s);
        bit          got;
        reply_item_t it;
        push_byte(b, s, got, it);
        if (got)
            pending_items.push_back(it);
    endtask

    // one reply frame with random content; now and then corrupted or cut short
    task automatic send_frame();
        logic [7:0]  fb[$];
        logic [7:0]  code;
        logic [15:0] c;
        int          len;
        int          kc;
        int          cut;
        int          k;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 90)
            len = $urandom_range(MIN_FRAME_LEN, 24);
        else if (r < 98)
            len = $urandom_range(25, 64);
        else if (r < 99)
            len = MAX_FRAME_LEN;
        else
            len = $urandom_range(200, MAX_FRAME_LEN);
        if ($urandom_range(0, 99) < 85)
        begin
            case ($urandom_range(0, 4))
                0: code = RC_ACK;
                1: code = RC_NAK;
                2: code = RC_RAW;
                3: code = RC_KPD;
                default: code = RC_COM;
            endcase
        end
        else
            code = 8'($urandom);
        // key count: mostly inside the frame, sometimes running past it
        if ($urandom_range(0, 99) < 80)
            kc = $urandom_range(0, len - 8);
        else
            kc = $urandom_range(0, 255);
        fb.push_back(SOM_BYTE);
        fb.push_back(8'($urandom));
        fb.push_back(len[7:0]);
        fb.push_back(len[15:8]);
        fb.push_back(8'($urandom));
        fb.push_back(code);
        for (int i = 6; i < len - 2; i++)
        begin
            fb.push_back((i == 7 && code == RC_KPD) ? 8'(kc) : 8'($urandom));
        end
        c = CRC_INIT;
        foreach (fb[i])
            c = crc16_update(c, fb[i]);
        fb.push_back(c[7:0]);
        fb.push_back(c[15:8]);
        // single bit error anywhere after the start byte
        if ($urandom_range(0, 9) == 0)
        begin
            k = $urandom_range(1, len - 1);
            fb[k] = fb[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, len - 1) : len;
        for (int i = 0; i < cut; i++)
        begin
            send_tracked(fb[i], i == 0);
        end
    endtask

    // stray bytes, bad start bytes and bad length headers
    task automatic send_noise();
        logic [7:0]  b;
        logic [15:0] lv;
        case ($urandom_range(0, 2))
            0:
            begin
                repeat ($urandom_range(1, 3))
                    send_tracked(8'($urandom), 1'b0);
            end
            1:
            begin
                b = 8'($urandom);
                if (b == SOM_BYTE)
                    b = ~b;
                send_tracked(b, 1'b1);
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0: lv = 16'($urandom_range(0, MIN_FRAME_LEN - 1));
                    1: lv = 16'(MAX_FRAME_LEN + 1);
                    2: lv = 16'hFFFF;
                    default: lv = 16'($urandom_range(MAX_FRAME_LEN + 1, 65535));
                endcase
                send_tracked(SOM_BYTE, 1'b1);
                send_tracked(8'($urandom), 1'b0);
                send_tracked(lv[7:0], 1'b0);
                send_tracked(lv[15:8], 1'b0);
            end
        endcase
    endtask

    task automatic check_field(input string fname, input logic [7:0] want,
                               input logic [7:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, seen);
            err_count++;
        end
    endtask

    // result side: compare each accepted item with the oldest expectation
    always @(posedge clk)
    begin
        reply_item_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_items.size() == 0)
            begin
                $error("item_kind: unexpected item, kind 0x%0h status 0x%0h",
                       res_ch.item_kind, res_ch.frame_status);
                err_count++;
            end
            else
            begin
                want = pending_items.pop_front();
                check_field("item_kind", 8'(want.kind), 8'(res_ch.item_kind));
                check_field("payload_byte", want.payload, res_ch.payload_byte);
                check_field("reply_code", want.code, res_ch.reply_code);
                check_field("frame_status", 8'(want.status), 8'(res_ch.frame_status));
                check_field("frame_end", 8'(want.fend), 8'(res_ch.frame_end));
            end
        end
    end

    // result side back-pressure: random stalls, none started while calm
    initial
    begin
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                res_ch.ready = 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = gap_len();
            end
        end
    end

    // main stimulus
    initial
    begin
        logic [7:0]  b;
        bit          got;
        reply_item_t it;
        err_count         = 0;
        byte_count        = 0;
        calm              = 1'b0;
        trk_phase         = PH_IDLE;
        trk_pos           = '0;
        trk_len           = '0;
        trk_crc           = CRC_INIT;
        trk_code          = '0;
        trk_keys          = '0;
        trk_crc_lo        = '0;
        rst_n             = 1'b0;
        rx_ch.valid       = 1'b0;
        rx_ch.rx_byte     = '0;
        rx_ch.frame_start = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table; crc bytes come from the tracked running crc
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            case (PLAN[i].fill)
                FILL_CRC_LO:  b = trk_crc[7:0];
                FILL_CRC_HI:  b = trk_crc[15:8];
                FILL_CRC_BAD: b = ~trk_crc[15:8];
                default:      b = PLAN[i].b;
            endcase
            push_byte(b, PLAN[i].s, got, it);
            if (PLAN[i].typed)
            begin
                if (PLAN[i].exp_got)
                    pending_items.push_back(PLAN[i].exp);
            end
            else if (got)
                pending_items.push_back(it);
        end

        // random traffic: mostly well-formed frames, some noise
        byte_count = 0;
        while (byte_count < RAND_BYTES)
        begin
            if ($urandom_range(0, 15) == 0)
                calm = !calm;
            if ($urandom_range(0, 99) < 85)
                send_frame();
            else
                send_noise();
        end
        rx_ch.valid = 1'b0;
        calm        = 1'b0;

        // drain, then watch a little longer for stray items
        while (pending_items.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // hard limit on the run
    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
